// ----- rtl/cmlb_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants and types for the circular message log buffer.
// No dependencies; imported by cmlb_alloc, the top module and the testbench.
package cmlb_pkg;

  // log geometry
  localparam int LOG_SIZE   = 4096;
  localparam int STAMP_ROOM = 24;
  localparam int HALF_SIZE  = LOG_SIZE / 2;
  localparam int AW         = $clog2(LOG_SIZE);      // memory address bits
  localparam int PW         = AW + 1;                // position bits, 0..LOG_SIZE
  localparam int KW         = $clog2(HALF_SIZE + 1); // kept length bits
  localparam int LW         = 16;                    // message length field
  localparam int CW         = 32;                    // entry counter

  localparam logic [7:0] NEWLINE = 8'h0A;

  // stream payload widths
  localparam int IN_DW  = 24;
  localparam int IN_UW  = 2;
  localparam int OUT_DW = 56;
  localparam int OUT_UW = 1;

  // item function selector
  typedef enum logic [1:0] {
    FN_APPEND = 2'd0,
    FN_CLEAR  = 2'd1,
    FN_RSTART = 2'd2,
    FN_RNEXT  = 2'd3
  } func_t;

  // message status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_TRUNC = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RDATA
  } state_t;

  // placement decision for a new message
  typedef struct packed {
    logic [KW-1:0] keep_len;
    logic [PW-1:0] base;
    logic [PW-1:0] wp_new;
    logic [PW-1:0] em_new;
    logic [1:0]    status;
    logic          drop;
  } alloc_t;

endpackage

// ----- rtl/cmlb_ram.sv -----
`timescale 1ns / 1ps
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module cmlb_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ----- rtl/cmlb_alloc.sv -----
`timescale 1ns / 1ps
// Placement of a new message: kept length, base, new write position, end mark, status and drop.
// Depends on cmlb_pkg.
module cmlb_alloc (
  input  logic [cmlb_pkg::LW-1:0] msg_len,
  input  logic [cmlb_pkg::PW-1:0] write_pos,
  input  logic [cmlb_pkg::PW-1:0] end_mark,
  input  logic                    log_mode,
  output cmlb_pkg::alloc_t        alloc
);
  import cmlb_pkg::*;

  logic [KW-1:0] len_cap;
  logic          over_half;
  logic [PW:0]   span;
  logic [PW:0]   stamp_end;
  logic          no_fit;
  logic          room_left;
  logic [PW-1:0] tail_len;

  // cap the message at half the log
  assign over_half = msg_len > LW'(HALF_SIZE);
  assign len_cap   = over_half ? KW'(HALF_SIZE) : msg_len[KW-1:0];

  // fit checks against the current write position
  assign span      = {1'b0, write_pos} + (PW+1)'(len_cap);
  assign no_fit    = span > (PW+1)'(LOG_SIZE);
  assign stamp_end = {1'b0, write_pos} + (PW+1)'(STAMP_ROOM);
  assign room_left = stamp_end < (PW+1)'(LOG_SIZE);
  assign tail_len  = PW'(LOG_SIZE) - write_pos;

  always_comb begin
    logic [PW-1:0] em;
    logic [PW-1:0] wp_end;
    em              = end_mark;
    alloc.keep_len  = len_cap;
    alloc.base      = write_pos;
    alloc.status    = over_half ? STAT_TRUNC : STAT_OK;
    alloc.drop      = 1'b0;
    if (no_fit) begin
      if (log_mode) begin
        // wrap to the start, old write position marks the end
        em         = write_pos;
        alloc.base = '0;
      end else if (room_left) begin
        // keep what fits up to the physical end
        alloc.keep_len = tail_len[KW-1:0];
        alloc.status   = STAT_TRUNC;
      end else begin
        alloc.keep_len = '0;
        alloc.status   = STAT_FULL;
        alloc.drop     = 1'b1;
      end
    end
    wp_end       = alloc.base + PW'(alloc.keep_len);
    alloc.wp_new = wp_end;
    alloc.em_new = (wp_end > em) ? wp_end : em;
  end

endmodule

// ----- rtl/circular_message_log_buffer_top.sv -----
`timescale 1ns / 1ps
// Circular message log buffer: sequencer, log pointers and result register.
// Depends on cmlb_pkg, cmlb_ram and cmlb_alloc.
// Append, clear and an empty read load the result register from the input beat;
// read next byte does one log memory read and loads the result in S_RDATA; read start
// reads a byte, then in S_SCAN checks each byte read and fetches the next, up to the end mark.
// One item is in flight at a time; the single log memory port sets the pace.
// Reset (rst_n low, synchronous) clears all pointers, counters and the mode;
// log memory contents are undefined until written and get no clearing pass.
module circular_message_log_buffer_top (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration: log_mode
  input  logic                         cfg_wen,
  input  logic                         cfg_wdata,
  // input beats
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [cmlb_pkg::IN_DW-1:0]   in_tdata,   // data_byte[7:0], msg_len[23:8]
  input  logic [cmlb_pkg::IN_UW-1:0]   in_tuser,   // func[1:0]
  // result beats
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [cmlb_pkg::OUT_DW-1:0]  out_tdata,  // status[1:0], read_byte[9:2],
                                                   // entry_count[41:10],
                                                   // fill_index[54:42], zero pad
  output logic [cmlb_pkg::OUT_UW-1:0]  out_tuser   // read_valid[0]
);
  import cmlb_pkg::*;

  state_t state_r, state_nxt;

  logic          log_mode_r;
  logic [PW-1:0] write_pos_r, write_pos_nxt;
  logic [PW-1:0] end_mark_r, end_mark_nxt;
  logic [CW-1:0] stored_count_r, stored_count_nxt;
  logic [LW-1:0] byte_pos_r, byte_pos_nxt;
  logic [KW-1:0] kept_len_r, kept_len_nxt;
  logic [PW-1:0] msg_base_r, msg_base_nxt;
  logic [1:0]    msg_status_r, msg_status_nxt;
  logic [PW-1:0] read_pos_r, read_pos_nxt;
  logic [PW-1:0] read_left_r, read_left_nxt;
  logic [PW-1:0] read_end_r, read_end_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [OUT_DW-1:0] out_data_r, out_data_nxt;
  logic [OUT_UW-1:0] out_user_r, out_user_nxt;

  logic          accept;
  func_t         func;
  logic [7:0]    data_byte;
  logic [LW-1:0] msg_len;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata, mem_rdata;

  alloc_t        alloc;

  // scan step values
  logic [PW-1:0] scan_pos_inc;
  logic [PW-1:0] scan_left_dec;
  logic          scan_more;

  // read next position after wrap
  logic [PW-1:0] rd_pos;

  // result produced this cycle
  logic          res_load;
  logic [1:0]    res_status;
  logic [7:0]    res_byte;
  logic          res_valid;

  assign func      = func_t'(in_tuser);
  assign data_byte = in_tdata[7:0];
  assign msg_len   = in_tdata[23:8];

  // one item at a time, result register free or draining
  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  cmlb_ram #(
    .DEPTH (LOG_SIZE),
    .WIDTH (8)
  ) u_log_mem (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  cmlb_alloc u_alloc (
    .msg_len   (msg_len),
    .write_pos (write_pos_r),
    .end_mark  (end_mark_r),
    .log_mode  (log_mode_r),
    .alloc     (alloc)
  );

  assign scan_pos_inc  = read_pos_r + PW'(1);
  assign scan_left_dec = read_left_r - PW'(1);
  assign scan_more     = (mem_rdata != NEWLINE) && (scan_left_dec != '0) &&
                         (scan_pos_inc < read_end_r);
  assign rd_pos        = (read_pos_r >= read_end_r) ? '0 : read_pos_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (func == FN_RSTART && end_mark_r != '0 && write_pos_r < end_mark_r) begin
            state_nxt = S_SCAN;
          end else if (func == FN_RNEXT && read_left_r != '0 && rd_pos < read_end_r) begin
            state_nxt = S_RDATA;
          end
        end
      end
      S_SCAN: begin
        if (!scan_more) begin
          state_nxt = S_IDLE;
        end
      end
      S_RDATA: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath, memory control and result
  always_comb begin
    logic [KW-1:0] kl;
    logic [PW-1:0] mb;
    logic [1:0]    ms;
    logic [LW:0]   bp_inc;
    write_pos_nxt    = write_pos_r;
    end_mark_nxt     = end_mark_r;
    stored_count_nxt = stored_count_r;
    byte_pos_nxt     = byte_pos_r;
    kept_len_nxt     = kept_len_r;
    msg_base_nxt     = msg_base_r;
    msg_status_nxt   = msg_status_r;
    read_pos_nxt     = read_pos_r;
    read_left_nxt    = read_left_r;
    read_end_nxt     = read_end_r;
    mem_we           = 1'b0;
    mem_re           = 1'b0;
    mem_addr         = '0;
    mem_wdata        = data_byte;
    res_load         = 1'b0;
    res_status       = STAT_OK;
    res_byte         = '0;
    res_valid        = 1'b0;
    kl               = kept_len_r;
    mb               = msg_base_r;
    ms               = msg_status_r;
    bp_inc           = {1'b0, byte_pos_r} + (LW+1)'(1);
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (func)
            FN_APPEND: begin
              res_load = 1'b1;
              if (msg_len == '0) begin
                byte_pos_nxt = '0;
              end else begin
                // first byte places the message
                if (byte_pos_r == '0) begin
                  kl             = alloc.keep_len;
                  mb             = alloc.drop ? write_pos_r : alloc.base;
                  ms             = alloc.status;
                  kept_len_nxt   = kl;
                  msg_base_nxt   = mb;
                  msg_status_nxt = ms;
                  if (!alloc.drop) begin
                    write_pos_nxt    = alloc.wp_new;
                    end_mark_nxt     = alloc.em_new;
                    stored_count_nxt = stored_count_r + CW'(1);
                  end
                end
                // store the byte, last kept byte forced to newline
                if (byte_pos_r < LW'(kl)) begin
                  mem_we    = 1'b1;
                  mem_addr  = AW'(mb + PW'(byte_pos_r[KW-1:0]));
                  mem_wdata = (bp_inc == (LW+1)'(kl)) ? NEWLINE : data_byte;
                end
                res_status   = ms;
                byte_pos_nxt = (bp_inc >= (LW+1)'(msg_len)) ? '0 : bp_inc[LW-1:0];
              end
            end
            FN_CLEAR: begin
              res_load         = 1'b1;
              write_pos_nxt    = '0;
              end_mark_nxt     = '0;
              stored_count_nxt = '0;
              kept_len_nxt     = '0;
            end
            FN_RSTART: begin
              // scan works directly in the read registers
              read_pos_nxt  = write_pos_r;
              read_left_nxt = end_mark_r;
              read_end_nxt  = end_mark_r;
              if (end_mark_r != '0 && write_pos_r < end_mark_r) begin
                mem_re   = 1'b1;
                mem_addr = write_pos_r[AW-1:0];
              end else begin
                res_load = 1'b1;
              end
            end
            FN_RNEXT: begin
              if (read_left_r != '0) begin
                read_pos_nxt = rd_pos;
                if (rd_pos < read_end_r) begin
                  mem_re        = 1'b1;
                  mem_addr      = rd_pos[AW-1:0];
                  read_pos_nxt  = rd_pos + PW'(1);
                  read_left_nxt = read_left_r - PW'(1);
                end else begin
                  res_load = 1'b1;
                end
              end else begin
                res_load = 1'b1;
              end
            end
            default: res_load = 1'b1;
          endcase
        end
      end
      S_SCAN: begin
        // check the byte read last cycle, fetch the next one
        read_pos_nxt  = scan_pos_inc;
        read_left_nxt = scan_left_dec;
        if (scan_more) begin
          mem_re   = 1'b1;
          mem_addr = scan_pos_inc[AW-1:0];
        end else begin
          res_load = 1'b1;
        end
      end
      S_RDATA: begin
        res_load  = 1'b1;
        res_byte  = mem_rdata;
        res_valid = 1'b1;
      end
      default: ;
    endcase
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {1'b0, write_pos_nxt, stored_count_nxt, res_byte, res_status};
      out_user_nxt  = res_valid;
    end
  end

  // control and pointer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      log_mode_r     <= 1'b0;
      write_pos_r    <= '0;
      end_mark_r     <= '0;
      stored_count_r <= '0;
      byte_pos_r     <= '0;
      kept_len_r     <= '0;
      msg_base_r     <= '0;
      msg_status_r   <= STAT_OK;
      read_pos_r     <= '0;
      read_left_r    <= '0;
      read_end_r     <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      if (cfg_wen) begin
        log_mode_r <= cfg_wdata;
      end
      write_pos_r    <= write_pos_nxt;
      end_mark_r     <= end_mark_nxt;
      stored_count_r <= stored_count_nxt;
      byte_pos_r     <= byte_pos_nxt;
      kept_len_r     <= kept_len_nxt;
      msg_base_r     <= msg_base_nxt;
      msg_status_r   <= msg_status_nxt;
      read_pos_r     <= read_pos_nxt;
      read_left_r    <= read_left_nxt;
      read_end_r     <= read_end_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for circular_message_log_buffer_top: a directed table, then random
// message, read, clear and noise traffic, each result checked against the table or a local log model.
// Depends on cmlb_pkg and the RTL of the block only.
module tb_top;
  import cmlb_pkg::*;

  localparam int DIR_N       = 26;
  localparam int N_PHASES    = 6;
  localparam int PHASE_ITEMS = 150;
  localparam int TAIL_CYCLES = 20;
  localparam int DRAIN_LIMIT = 50000;
  // ~1000 beats, each at worst a full 4096 byte scan plus stalls and gaps, taken 4x over
  localparam int MAX_CYCLES  = 20000000;

  // one result beat, unpacked
  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  rbyte;
    logic        rvalid;
    logic [31:0] count;
    logic [12:0] fill;
  } log_result_t;

  // one row of the directed table; a cfg row writes d[0] as the mode
  typedef struct packed {
    bit          cfg;
    func_t       f;
    logic [7:0]  d;
    logic [15:0] len;
    bit          fixed;
    log_result_t res;
  } dir_row_t;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                cfg_wen   = 1'b0;
  logic                cfg_wdata = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [IN_DW-1:0]    in_tdata  = '0;    // data_byte[7:0], msg_len[23:8]
  logic [IN_UW-1:0]    in_tuser  = '0;    // func[1:0]
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_DW-1:0]   out_tdata;         // status, read_byte, entry_count, fill_index
  logic [OUT_UW-1:0]   out_tuser;         // read_valid[0]

  // log model state
  logic [7:0]  log_image [LOG_SIZE];
  bit          loaded    [LOG_SIZE];
  bit          overwrite_mode;
  int unsigned fill_pos, end_pos, msg_total;
  int unsigned msg_offset, keep_len, msg_start, msg_stat;
  int unsigned rd_pos, rd_left, rd_limit;

  log_result_t result_q [$];
  dir_row_t    dir_rows [DIR_N];

  int errors, beats_sent, results_seen, rand_items, cycle_count;
  int truncs_seen, drops_seen, wraps_seen, bytes_read;
  int burst_left;
  bit gaps_on = 1'b1;
  int stall_left, stall_mode, stall_tick;

  circular_message_log_buffer_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // log model: apply one accepted beat and return the result it should give
  function automatic log_result_t log_step(input func_t f, input logic [7:0] d,
                                           input logic [15:0] len);
    log_result_t r;
    int unsigned wp, em, keep, st, idx, left;
    bit          hit;
    r = '0;
    case (f)
      FN_APPEND: begin
        if (len == 0) begin
          msg_offset = 0;
        end else begin
          // first byte decides placement, kept length and status
          if (msg_offset == 0) begin
            wp   = fill_pos;
            em   = end_pos;
            st   = 32'(STAT_OK);
            keep = 32'(len);
            if (keep > HALF_SIZE) begin
              keep = HALF_SIZE;
              st   = 32'(STAT_TRUNC);
            end
            if (wp + keep > LOG_SIZE) begin
              if (overwrite_mode) begin
                em = wp;
                wp = 0;
                wraps_seen++;
              end else if (wp + STAMP_ROOM < LOG_SIZE) begin
                keep = LOG_SIZE - wp;
                st   = 32'(STAT_TRUNC);
              end else begin
                keep = 0;
              end
            end
            if (keep == 0) begin
              msg_stat  = 32'(STAT_FULL);
              keep_len  = 0;
              msg_start = fill_pos;
              drops_seen++;
            end else begin
              msg_stat  = st;
              keep_len  = keep;
              msg_start = wp;
              wp        = wp + keep;
              if (wp > em) em = wp;
              fill_pos  = wp;
              end_pos   = em;
              msg_total = msg_total + 1;
              if (st == 32'(STAT_TRUNC)) truncs_seen++;
            end
          end
          // last kept byte always lands as a newline
          if (msg_offset < keep_len) begin
            log_image[msg_start + msg_offset] = (msg_offset + 1 == keep_len) ? NEWLINE : d;
            loaded[msg_start + msg_offset]    = 1'b1;
          end
          r.status = 2'(msg_stat);
          if (msg_offset + 1 >= 32'(len)) msg_offset = 0;
          else msg_offset = msg_offset + 1;
        end
      end
      FN_CLEAR: begin
        fill_pos  = 0;
        end_pos   = 0;
        msg_total = 0;
        keep_len  = 0;
      end
      FN_RSTART: begin
        // skip the oldest fragment up to and including its newline
        idx  = fill_pos;
        left = end_pos;
        hit  = 1'b0;
        while (!hit && left > 0 && idx < end_pos) begin
          hit  = (log_image[idx] == NEWLINE);
          idx  = idx + 1;
          left = left - 1;
        end
        rd_left  = left;
        rd_pos   = idx;
        rd_limit = end_pos;
      end
      default: begin
        if (rd_left > 0) begin
          if (rd_pos >= rd_limit) rd_pos = 0;
          if (rd_pos < rd_limit) begin
            r.rbyte  = log_image[rd_pos];
            r.rvalid = 1'b1;
            rd_pos   = rd_pos + 1;
            rd_left  = rd_left - 1;
            bytes_read++;
          end
        end
      end
    endcase
    r.count = msg_total;
    r.fill  = 13'(fill_pos);
    return r;
  endfunction

  // send one beat in bursts with random gaps, then record what it should produce
  task automatic drive_item(input func_t f, input logic [7:0] d, input logic [15:0] len,
                            input bit fixed, input log_result_t fixed_res);
    log_result_t r;
    int          gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (gaps_on) gap = $urandom_range(0, 6);
    end
    burst_left--;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tuser  <= f;
    in_tdata  <= {len, d};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    r = log_step(f, d, len);
    result_q.push_back(fixed ? fixed_res : r);
    beats_sent++;
    @(negedge clk);
  endtask

  // random beat; a read that would touch never-written log bytes becomes an empty append
  task automatic issue(input func_t f, input logic [7:0] d, input logic [15:0] len);
    int unsigned idx, left, pos;
    bit          bad, hit;
    bad = 1'b0;
    hit = 1'b0;
    if (f == FN_RSTART) begin
      idx  = fill_pos;
      left = end_pos;
      while (!bad && !hit && left > 0 && idx < end_pos) begin
        bad  = !loaded[idx];
        hit  = (log_image[idx] == NEWLINE);
        idx  = idx + 1;
        left = left - 1;
      end
    end else if (f == FN_RNEXT && rd_left > 0) begin
      pos = (rd_pos >= rd_limit) ? 0 : rd_pos;
      bad = (pos < rd_limit) && !loaded[pos];
    end
    if (bad) begin
      f   = FN_APPEND;
      len = 16'd0;
    end
    drive_item(f, d, len, 1'b0, '0);
    rand_items++;
  endtask

  task automatic send_msg(input int unsigned len, input int unsigned nb);
    repeat (nb) issue(FN_APPEND, 8'($urandom), 16'(len));
  endtask

  // finish a message in progress with a byte whose length ends it
  task automatic end_open_msg();
    if (msg_offset != 0) issue(FN_APPEND, 8'($urandom), 16'(msg_offset + 1));
  endtask

  // mode write only once every pending result is back
  task automatic set_mode(input bit m);
    in_tvalid <= 1'b0;
    while (result_q.size() != 0) @(negedge clk);
    cfg_wdata <= m;
    cfg_wen   <= 1'b1;
    @(negedge clk);
    cfg_wen        <= 1'b0;
    overwrite_mode  = m;
    burst_left      = 0;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // receiver stall pattern, switching at random between always ready, random and periodic stalls
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(20, 80);
    end
    stall_left--;
    stall_tick++;
    case (stall_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(0, 9) < 6);
      default: out_tready <= (stall_tick % 4 != 0);
    endcase
  end

  // compare each result beat with the oldest expectation
  always @(posedge clk) begin : check_results
    log_result_t want;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      if (result_q.size() == 0) begin
        errors++;
        $display("%0t ns: result beat with nothing expected, actual %0h", $time, out_tdata);
      end else begin
        want = result_q.pop_front();
        results_seen++;
        check_field("status", 32'(want.status), 32'(out_tdata[1:0]));
        check_field("read_byte", 32'(want.rbyte), 32'(out_tdata[9:2]));
        check_field("read_valid", 32'(want.rvalid), 32'(out_tuser[0]));
        check_field("entry_count", want.count, out_tdata[41:10]);
        check_field("fill_index", 32'(want.fill), 32'(out_tdata[54:42]));
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int          i, phase, pick, n;
    int unsigned len, drain;

    // directed table: reset state, empty reads, extremes, clear mid-message,
    // fill to the end, drop when full, then overwrite wrap
    dir_rows = '{
      '{1'b1, FN_APPEND, 8'h00, 16'd0,    1'b0, '0},
      '{1'b0, FN_RNEXT,  8'hFF, 16'hFFFF, 1'b1, '{STAT_OK,    8'h00, 1'b0, 32'd0, 13'd0}},
      '{1'b0, FN_RSTART, 8'h00, 16'd0,    1'b1, '{STAT_OK,    8'h00, 1'b0, 32'd0, 13'd0}},
      '{1'b0, FN_APPEND, 8'h41, 16'd0,    1'b1, '{STAT_OK,    8'h00, 1'b0, 32'd0, 13'd0}},
      '{1'b0, FN_APPEND, 8'hFF, 16'd1,    1'b1, '{STAT_OK,    8'h00, 1'b0, 32'd1, 13'd1}},
      '{1'b0, FN_APPEND, 8'h00, 16'd2,    1'b1, '{STAT_OK,    8'h00, 1'b0, 32'd2, 13'd3}},
      '{1'b0, FN_APPEND, 8'hFF, 16'd2,    1'b1, '{STAT_OK,    8'h00, 1'b0, 32'd2, 13'd3}},
      '{1'b0, FN_RSTART, 8'h00, 16'd0,    1'b1, '{STAT_OK,    8'h00, 1'b0, 32'd2, 13'd3}},
      '{1'b0, FN_RNEXT,  8'h00, 16'd0,    1'b0, '0},
      '{1'b0, FN_RNEXT,  8'h00, 16'd0,    1'b0, '0},
      '{1'b0, FN_RNEXT,  8'h00, 16'd0,    1'b0, '0},
      '{1'b0, FN_RNEXT,  8'h00, 16'd0,    1'b1, '{STAT_OK,    8'h00, 1'b0, 32'd2, 13'd3}},
      '{1'b0, FN_APPEND, 8'h80, 16'hFFFF, 1'b1, '{STAT_TRUNC, 8'h00, 1'b0, 32'd3, 13'd2051}},
      '{1'b0, FN_APPEND, 8'h7F, 16'd2,    1'b0, '0},
      '{1'b0, FN_APPEND, 8'h33, 16'd5,    1'b0, '0},
      '{1'b0, FN_CLEAR,  8'h00, 16'd0,    1'b1, '{STAT_OK,    8'h00, 1'b0, 32'd0, 13'd0}},
      '{1'b0, FN_APPEND, 8'h34, 16'd2,    1'b0, '0},
      '{1'b0, FN_APPEND, 8'hAA, 16'hFFFF, 1'b1, '{STAT_TRUNC, 8'h00, 1'b0, 32'd1, 13'd2048}},
      '{1'b0, FN_APPEND, 8'h12, 16'd2,    1'b0, '0},
      '{1'b0, FN_APPEND, 8'h01, 16'hFFFF, 1'b1, '{STAT_TRUNC, 8'h00, 1'b0, 32'd2, 13'd4096}},
      '{1'b0, FN_APPEND, 8'h02, 16'd2,    1'b0, '0},
      '{1'b0, FN_APPEND, 8'h5A, 16'd1,    1'b1, '{STAT_FULL,  8'h00, 1'b0, 32'd2, 13'd4096}},
      '{1'b1, FN_APPEND, 8'h01, 16'd0,    1'b0, '0},
      '{1'b0, FN_APPEND, 8'h61, 16'd3,    1'b1, '{STAT_OK,    8'h00, 1'b0, 32'd3, 13'd3}},
      '{1'b0, FN_APPEND, 8'h62, 16'd3,    1'b0, '0},
      '{1'b0, FN_APPEND, 8'h63, 16'd3,    1'b0, '0}
    };

    // reset
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (i = 0; i < DIR_N; i++) begin
      if (dir_rows[i].cfg) set_mode(dir_rows[i].d[0]);
      else drive_item(dir_rows[i].f, dir_rows[i].d, dir_rows[i].len,
                      dir_rows[i].fixed, dir_rows[i].res);
    end

    // random phases, each with its own mode; one phase runs without sender gaps
    for (phase = 0; phase < N_PHASES; phase++) begin
      set_mode(phase < 2 ? (phase == 1) : ($urandom_range(0, 1) == 1));
      gaps_on = (phase != 3);
      if (phase == 0 || $urandom_range(0, 1) == 1)
        issue(FN_CLEAR, 8'($urandom), 16'($urandom));
      while (rand_items < (phase + 1) * PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          // complete message, mostly short
          end_open_msg();
          n   = $urandom_range(0, 9);
          len = (n < 7) ? $urandom_range(1, 24) : (n < 9) ? $urandom_range(25, 120) : 1;
          send_msg(len, len);
        end else if (pick < 57) begin
          // long or overlong message cut short after a few bytes
          end_open_msg();
          n   = $urandom_range(0, 2);
          len = (n == 0) ? 65535 : (n == 1) ? $urandom_range(2049, 65534)
                                            : $urandom_range(121, 2048);
          send_msg(len, $urandom_range(1, 3));
          end_open_msg();
        end else if (pick < 77) begin
          // read back from the oldest whole message
          issue(FN_RSTART, 8'($urandom), 16'($urandom));
          repeat ($urandom_range(1, 30)) issue(FN_RNEXT, 8'($urandom), 16'($urandom));
        end else if (pick < 82) begin
          // clear in the middle of a message
          end_open_msg();
          len = $urandom_range(3, 20);
          send_msg(len, len / 2);
          issue(FN_CLEAR, 8'($urandom), 16'($urandom));
          send_msg(len, len - len / 2);
        end else if (pick < 88) begin
          // read while a message is still arriving
          end_open_msg();
          len = $urandom_range(3, 20);
          send_msg(len, len / 2);
          issue(FN_RSTART, 8'($urandom), 16'($urandom));
          repeat ($urandom_range(1, 5)) issue(FN_RNEXT, 8'($urandom), 16'($urandom));
          send_msg(len, len - len / 2);
        end else begin
          // noise over the whole field ranges
          repeat ($urandom_range(1, 4))
            issue(func_t'($urandom_range(0, 3)), 8'($urandom), 16'($urandom_range(0, 65535)));
        end
      end
    end

    // drain
    in_tvalid <= 1'b0;
    drain = 0;
    while (result_q.size() != 0 && drain < DRAIN_LIMIT) begin
      @(negedge clk);
      drain++;
    end
    repeat (TAIL_CYCLES) @(negedge clk);
    if (result_q.size() != 0) begin
      errors++;
      $display("%0t ns: %0d expected results never arrived", $time, result_q.size());
    end

    $display("Covered %0d input beats and %0d result beats: %0d truncated, %0d dropped,",
             beats_sent, results_seen, truncs_seen, drops_seen);
    $display("%0d overwrite wraps and %0d log bytes read back", wraps_seen, bytes_read);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/cmlb_pkg.sv
rtl/cmlb_ram.sv
rtl/cmlb_alloc.sv
rtl/circular_message_log_buffer_top.sv
tb/tb_top.sv
